FILE: rtl/wfrm_pkg.sv
package wfrm_pkg;

  // configuration register indexes
  localparam logic CFG_RATE_WINDOW = 1'b0;
  localparam logic CFG_AVG_WINDOW  = 1'b1;

  localparam logic [31:0] WINDOW_RESET = 32'd1000000000;

  // 256e9 = 1953125 * 2^17
  localparam int          FPS_ODD_W  = 21;
  localparam logic [20:0] FPS_ODD    = 21'd1953125;
  localparam int          FPS_SHIFT  = 17;
  localparam int          PROD_W     = 32 + FPS_ODD_W;

  // shared divider geometry
  localparam int         QUO_W      = 38;
  localparam int         SUM_W      = 33;
  localparam int         STEP_W     = 6;
  localparam logic [5:0] FPS_STEPS  = 6'd38;
  localparam logic [5:0] MEAN_STEPS = 6'd33;

  localparam int FPS_W  = 38;
  localparam int MEAN_W = 33;
  localparam int OUT_TDATA_W = 112;

  // one classified item handed from front to back
  typedef struct packed {
    logic              fps_close;
    logic              mean_close;
    logic [31:0]       rate_count;
    logic [SUM_W-1:0]  rate_time;
    logic [31:0]       avg_count;
    logic [SUM_W-1:0]  avg_time;
    logic [31:0]       last_ns;
    logic              last_valid;
  } job_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_START,
    BK_DIV,
    BK_DONE
  } back_state_t;

endpackage

FILE: rtl/windowed_frame_rate_meter.sv
// Windowed frame rate meter.
// in_*  : one frame duration in ns per transfer (in_tdata[31:0]); zero is ignored.
// out_* : one result per input transfer, in order. out_tdata from bit 0 up:
//         fps_q8[37:0], mean_frame_ns[70:38], last_frame_ns[102:71],
//         last_valid[103], fps_updated[104], mean_updated[105], zero fill.
// cfg_* : index 0 sets the rate window, index 1 the average window (ns);
//         write only while the block is idle.
// The front end updates both window sums in the cycle of the input transfer and
// queues the item (two entries); the back end dequeues it once it is idle.
// An item that closes no window goes from the queue through the done state to the
// output register. An item that closes a window passes the multiply, start, divide
// and done states; in the divide state the bit-serial divider of each closing
// window runs, both in parallel if both close (38 steps for fps, 33 for the mean).
// The back end takes a new item only after the last one has left the done state.
// Reset restores both windows to 1e9 ns and clears sums, counts and latched
// values. When out_tready is low the result holds in the output register,
// the back end waits, the queue fills and in_tready drops.
module windowed_frame_rate_meter
  import wfrm_pkg::*;
#(
  parameter int TIME_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [31:0]            in_tdata,   // frame_time_ns
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // fps_q8, mean_frame_ns, last_frame_ns,
                                             // last_valid, fps_updated, mean_updated
  input  logic                   cfg_wr_en,
  input  logic                   cfg_index,
  input  logic [31:0]            cfg_wdata
);

  // only the low TIME_BITS bits of a duration count
  localparam logic [31:0] DUR_MASK =
      (TIME_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << TIME_BITS) - 64'd1);

  logic [31:0] dur;
  logic        q_full, q_push, q_pop, q_valid;
  job_t        push_job, pop_job;

  assign dur = in_tdata & DUR_MASK;

  wfrm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .dur       (dur),
    .dur_valid (in_tvalid),
    .dur_ready (in_tready),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (push_job)
  );

  wfrm_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .pop_job  (pop_job),
    .valid    (q_valid)
  );

  wfrm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_job      (pop_job),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

FILE: rtl/wfrm_front.sv
module wfrm_front
  import wfrm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [31:0] dur,
  input  logic        dur_valid,
  output logic        dur_ready,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        q_full,
  output logic        q_push,
  output job_t        q_job
);

  logic [31:0]      rate_win_r, avg_win_r;
  logic [31:0]      rate_win_nxt, avg_win_nxt;
  logic [SUM_W-1:0] rate_sum_r, avg_sum_r, rate_sum_nxt, avg_sum_nxt;
  logic [31:0]      rate_cnt_r, avg_cnt_r, rate_cnt_nxt, avg_cnt_nxt;
  logic [31:0]      last_r, last_nxt;
  logic             seen_r, seen_nxt;

  logic             take, nz;
  logic [SUM_W-1:0] rate_add, avg_add;
  logic [31:0]      rate_inc, avg_inc;
  logic             rate_close, avg_close;

  assign dur_ready = !q_full;
  assign take      = dur_valid && dur_ready;
  assign nz        = (dur != 32'd0);

  // a stored window sum stays below 2^32, so adding a 32-bit duration never overflows 33 bits
  assign rate_add = rate_sum_r + {1'b0, dur};
  assign avg_add  = avg_sum_r + {1'b0, dur};
  assign rate_inc = (rate_cnt_r == '1) ? rate_cnt_r : rate_cnt_r + 32'd1;
  assign avg_inc  = (avg_cnt_r == '1) ? avg_cnt_r : avg_cnt_r + 32'd1;
  assign rate_close = nz && (rate_add >= {1'b0, rate_win_r});
  assign avg_close  = nz && (avg_add >= {1'b0, avg_win_r});

  // job for the back end
  always_comb begin
    q_push           = take;
    q_job.fps_close  = rate_close;
    q_job.mean_close = avg_close;
    q_job.rate_count = rate_inc;
    q_job.rate_time  = rate_add;
    q_job.avg_count  = avg_inc;
    q_job.avg_time   = avg_add;
    q_job.last_ns    = nz ? dur : last_r;
    q_job.last_valid = seen_r || nz;
  end

  // window accumulators
  always_comb begin
    rate_sum_nxt = rate_sum_r;
    rate_cnt_nxt = rate_cnt_r;
    avg_sum_nxt  = avg_sum_r;
    avg_cnt_nxt  = avg_cnt_r;
    last_nxt     = last_r;
    seen_nxt     = seen_r;
    if (take && nz) begin
      rate_sum_nxt = rate_close ? '0 : rate_add;
      rate_cnt_nxt = rate_close ? '0 : rate_inc;
      avg_sum_nxt  = avg_close ? '0 : avg_add;
      avg_cnt_nxt  = avg_close ? '0 : avg_inc;
      last_nxt     = dur;
      seen_nxt     = 1'b1;
    end
  end

  // configuration writes
  always_comb begin
    rate_win_nxt = rate_win_r;
    avg_win_nxt  = avg_win_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        CFG_RATE_WINDOW: rate_win_nxt = cfg_wdata;
        CFG_AVG_WINDOW:  avg_win_nxt  = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_win_r <= WINDOW_RESET;
      avg_win_r  <= WINDOW_RESET;
      rate_sum_r <= '0;
      rate_cnt_r <= '0;
      avg_sum_r  <= '0;
      avg_cnt_r  <= '0;
      last_r     <= '0;
      seen_r     <= 1'b0;
    end else begin
      rate_win_r <= rate_win_nxt;
      avg_win_r  <= avg_win_nxt;
      rate_sum_r <= rate_sum_nxt;
      rate_cnt_r <= rate_cnt_nxt;
      avg_sum_r  <= avg_sum_nxt;
      avg_cnt_r  <= avg_cnt_nxt;
      last_r     <= last_nxt;
      seen_r     <= seen_nxt;
    end
  end

endmodule

FILE: rtl/wfrm_queue.sv
module wfrm_queue
  import wfrm_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output job_t pop_job,
  output logic valid
);

  // two-entry queue between front and back
  job_t       slot_r [2];
  logic       wr_ptr_r, rd_ptr_r, wr_ptr_nxt, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full    = (cnt_r == 2'd2);
  assign valid   = (cnt_r != 2'd0);
  assign pop_job = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) wr_ptr_nxt = !wr_ptr_r;
    if (pop)  rd_ptr_nxt = !rd_ptr_r;
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_job;
  end

endmodule

FILE: rtl/wfrm_div.sv
module wfrm_div
  import wfrm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [SUM_W-1:0]  rem_init,
  input  logic [QUO_W-1:0]  num_bits,
  input  logic [SUM_W-1:0]  divisor,
  input  logic [STEP_W-1:0] steps,
  output logic              busy,
  output logic [QUO_W-1:0]  quotient
);

  // restoring divider, one quotient bit per cycle; rem_init must be below divisor
  logic [SUM_W-1:0]  rem_r, rem_nxt;
  logic [QUO_W-1:0]  bits_r, bits_nxt;
  logic [QUO_W-1:0]  quo_r, quo_nxt;
  logic [SUM_W-1:0]  dvs_r, dvs_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic [SUM_W:0]    trial, diff;
  logic              fits;

  assign trial = {rem_r, bits_r[QUO_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign fits  = (trial >= {1'b0, dvs_r});

  always_comb begin
    rem_nxt  = rem_r;
    bits_nxt = bits_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      rem_nxt  = rem_init;
      bits_nxt = num_bits;
      quo_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = steps;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt  = fits ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
      bits_nxt = {bits_r[QUO_W-2:0], 1'b0};
      quo_nxt  = {quo_r[QUO_W-2:0], fits};
      cnt_nxt  = cnt_r - {{(STEP_W-1){1'b0}}, 1'b1};
      busy_nxt = (cnt_r != {{(STEP_W-1){1'b0}}, 1'b1});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    bits_r <= bits_nxt;
    quo_r  <= quo_nxt;
    dvs_r  <= dvs_nxt;
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

FILE: rtl/wfrm_back.sv
module wfrm_back
  import wfrm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  input  job_t                   q_job,
  output logic                   q_pop,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  back_state_t state_r, state_nxt;

  job_t              job_r;
  logic [PROD_W-1:0] prod_r;
  logic [FPS_W-1:0]  fps_lat_r;
  logic [MEAN_W-1:0] mean_lat_r;
  logic              out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  logic load_job, do_mul, start_fps, start_mean, latch, load_out, divs_idle;
  logic fps_busy, mean_busy;
  logic [QUO_W-1:0] fps_quo, mean_quo;
  logic [SUM_W-1:0] fps_rem0, mean_div;
  logic [QUO_W-1:0] fps_bits, mean_bits;

  assign divs_idle = !fps_busy && !mean_busy;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE:
        if (q_valid) begin
          state_nxt = (q_job.fps_close || q_job.mean_close) ? BK_MUL : BK_DONE;
        end
      BK_MUL:   state_nxt = BK_START;
      BK_START: state_nxt = BK_DIV;
      BK_DIV:   if (divs_idle) state_nxt = BK_DONE;
      BK_DONE:  if (!out_valid_r || out_tready) state_nxt = BK_IDLE;
      default:  state_nxt = BK_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    load_job   = 1'b0;
    do_mul     = 1'b0;
    start_fps  = 1'b0;
    start_mean = 1'b0;
    latch      = 1'b0;
    load_out   = 1'b0;
    case (state_r)
      BK_IDLE:  load_job = q_valid;
      BK_MUL:   do_mul = 1'b1;
      BK_START: begin
        start_fps  = job_r.fps_close;
        start_mean = job_r.mean_close;
      end
      BK_DIV:   latch = divs_idle;
      BK_DONE:  load_out = !out_valid_r || out_tready;
      default: ;
    endcase
  end

  assign q_pop = load_job;

  // fps = count*1953125*2^17 / time; the quotient fits 38 bits since count <= time
  assign fps_rem0 = {1'b0, prod_r[PROD_W-1:FPS_ODD_W]};
  assign fps_bits = {prod_r[FPS_ODD_W-1:0], {FPS_SHIFT{1'b0}}};
  assign mean_div = {1'b0, job_r.avg_count};
  assign mean_bits = {job_r.avg_time, {(QUO_W-SUM_W){1'b0}}};

  wfrm_div u_fps_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start_fps),
    .rem_init (fps_rem0),
    .num_bits (fps_bits),
    .divisor  (job_r.rate_time),
    .steps    (FPS_STEPS),
    .busy     (fps_busy),
    .quotient (fps_quo)
  );

  wfrm_div u_mean_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start_mean),
    .rem_init ({SUM_W{1'b0}}),
    .num_bits (mean_bits),
    .divisor  (mean_div),
    .steps    (MEAN_STEPS),
    .busy     (mean_busy),
    .quotient (mean_quo)
  );

  // control and latched results
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      fps_lat_r   <= '0;
      mean_lat_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (latch && job_r.fps_close)  fps_lat_r  <= fps_quo[FPS_W-1:0];
      if (latch && job_r.mean_close) mean_lat_r <= mean_quo[MEAN_W-1:0];
      if (load_out)        out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (load_job) job_r  <= q_job;
    if (do_mul)   prod_r <= PROD_W'(job_r.rate_count) * PROD_W'(FPS_ODD);
    if (load_out) begin
      out_data_r <= {6'd0, job_r.mean_close, job_r.fps_close, job_r.last_valid,
                     job_r.last_ns, mean_lat_r, fps_lat_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

FILE: test/frame_meter_checker.sv
module frame_meter_checker
  import wfrm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [31:0]            in_tdata,   // frame_time_ns
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,  // fps_q8, mean_frame_ns, last_frame_ns,
                                             // last_valid, fps_updated, mean_updated
  input  logic                   cfg_wr_en,
  input  logic                   cfg_index,
  input  logic [31:0]            cfg_wdata,
  output int                     error_count,
  output int                     pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // one predicted meter reading
  typedef struct packed {
    logic [FPS_W-1:0]  fps_q8;
    logic [MEAN_W-1:0] mean_ns;
    logic [31:0]       last_ns;
    logic              last_valid;
    logic              fps_updated;
    logic              mean_updated;
  } meter_reading_t;

  meter_reading_t    readings_q[$];
  meter_reading_t    want;

  // shadow of the block's limits and window state
  logic [31:0]       rate_limit;
  logic [31:0]       avg_limit;
  logic [32:0]       rate_sum;
  logic [32:0]       avg_sum;
  logic [31:0]       rate_frames;
  logic [31:0]       avg_frames;
  logic [FPS_W-1:0]  fps_hold;
  logic [MEAN_W-1:0] mean_hold;
  logic [31:0]       last_dur;
  logic              seen;
  int                errs = 0;

  // fold one frame into both windows and return the reading it produces
  function automatic meter_reading_t account_frame(input logic [31:0] dur);
    meter_reading_t r;
    logic [79:0]    scaled;
    logic [32:0]    mean_q;
    r.fps_updated  = 1'b0;
    r.mean_updated = 1'b0;
    if (dur != 32'd0) begin
      last_dur = dur;
      seen     = 1'b1;
      rate_sum = rate_sum + {1'b0, dur};
      avg_sum  = avg_sum + {1'b0, dur};
      if (rate_frames != '1) rate_frames = rate_frames + 32'd1;
      if (avg_frames != '1) avg_frames = avg_frames + 32'd1;

      // fps in Q8: frames * 256e9 / time, truncated
      if (rate_sum >= {1'b0, rate_limit}) begin
        scaled      = rate_frames;
        scaled      = scaled * 80'd256000000000;
        scaled      = scaled / rate_sum;
        fps_hold    = scaled[FPS_W-1:0];
        rate_sum    = '0;
        rate_frames = '0;
        r.fps_updated = 1'b1;
      end

      // mean: 33-bit sum over a nonzero count always fits 33 bits
      if (avg_sum >= {1'b0, avg_limit}) begin
        mean_q     = avg_sum / avg_frames;
        mean_hold  = mean_q;
        avg_sum    = '0;
        avg_frames = '0;
        r.mean_updated = 1'b1;
      end
    end
    r.fps_q8     = fps_hold;
    r.mean_ns    = mean_hold;
    r.last_ns    = last_dur;
    r.last_valid = seen;
    return r;
  endfunction

  function automatic void compare_field(input string name, input logic [63:0] exp_v,
                                        input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errs++;
    end
  endfunction

  // watch transfers on all three ports
  always @(posedge clk) begin
    if (!rst_n) begin
      rate_limit  = WINDOW_RESET;
      avg_limit   = WINDOW_RESET;
      rate_sum    = '0;
      avg_sum     = '0;
      rate_frames = '0;
      avg_frames  = '0;
      fps_hold    = '0;
      mean_hold   = '0;
      last_dur    = '0;
      seen        = 1'b0;
      readings_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (readings_q.size() == 0) begin
          $error("out: result transfer with no frame outstanding");
          errs++;
        end else begin
          want = readings_q[0];
          readings_q.delete(0);
          compare_field("fps_q8",        want.fps_q8,       out_tdata[37:0]);
          compare_field("mean_frame_ns", want.mean_ns,      out_tdata[70:38]);
          compare_field("last_frame_ns", want.last_ns,      out_tdata[102:71]);
          compare_field("last_valid",    want.last_valid,   out_tdata[103]);
          compare_field("fps_updated",   want.fps_updated,  out_tdata[104]);
          compare_field("mean_updated",  want.mean_updated, out_tdata[105]);
        end
      end
      if (in_tvalid && in_tready) begin
        readings_q.insert(readings_q.size(), account_frame(in_tdata));
      end
      if (cfg_wr_en) begin
        if (cfg_index == CFG_RATE_WINDOW) rate_limit = cfg_wdata;
        else if (cfg_index == CFG_AVG_WINDOW) avg_limit = cfg_wdata;
      end
    end
    error_count <= errs;
    pending     <= readings_q.size();
  end

endmodule

FILE: test/tb_top.sv
module tb_top
  import wfrm_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [31:0]            in_tdata;    // frame_time_ns
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;   // fps_q8, mean_frame_ns, last_frame_ns,
                                       // last_valid, fps_updated, mean_updated
  logic                   cfg_wr_en;
  logic                   cfg_index;
  logic [31:0]            cfg_wdata;
  int                     error_count;
  int                     pending;
  int                     send_idle_pct = 29;
  int                     recv_idle_pct = 69;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  windowed_frame_rate_meter u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  frame_meter_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .error_count (error_count),
    .pending     (pending)
  );

  // receiver back-pressure
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // one frame transfer, with an optional random gap ahead of it
  task automatic send_frame(input logic [31:0] dur);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= dur;
    do @(posedge clk); while (!in_tready);
  endtask

  // stop sending and wait for every outstanding result
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic reconfigure(input logic [31:0] rate_ns, input logic [31:0] avg_ns);
    drain();
    repeat (2) @(posedge clk);
    write_reg(CFG_RATE_WINDOW, rate_ns);
    write_reg(CFG_AVG_WINDOW, avg_ns);
  endtask

  // window limit: small, display-like, any 32-bit value, or an extreme
  function automatic logic [31:0] pick_window();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(1, 100_000);
      1:       return $urandom_range(1_000_000, 1_000_000_000);
      2:       return $urandom();
      default: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
    endcase
  endfunction

  // frame duration: mostly a fraction of the window, plus zeros and odd values
  function automatic logic [31:0] pick_frame(input logic [31:0] span);
    int unsigned pick;
    logic [31:0] base;
    pick = $urandom_range(0, 99);
    if (pick < 8) return 32'd0;
    if (pick < 16) return $urandom();
    if (pick < 20) begin
      case ($urandom_range(0, 2))
        0:       return 32'd1;
        1:       return 32'hFFFF_FFFF;
        default: return $urandom_range(1, 16);
      endcase
    end
    base = (span == 32'd0) ? 32'd16_666_667 : span / $urandom_range(1, 40);
    return base - $urandom_range(0, base / 8);
  endfunction

  initial begin
    logic [31:0] rate_w;
    logic [31:0] avg_w;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_wr_en = 1'b0;
    cfg_index = CFG_RATE_WINDOW;
    cfg_wdata = '0;
    rst_n     = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero before any frame, extremes, a typical frame rate
    send_frame(32'd0);
    send_frame(32'd1);
    send_frame(32'hFFFF_FFFF);
    send_frame(32'd0);
    repeat (3) send_frame(32'd16_666_667);
    send_frame(32'hAAAA_AAAA);
    send_frame(32'h5555_5555);

    // zero limit closes on every nonzero frame, max limit needs a huge sum
    reconfigure(32'd0, 32'hFFFF_FFFF);
    send_frame(32'd1000);
    send_frame(32'd0);
    send_frame(32'hFFFF_FFFF);
    send_frame(32'd7);

    // part-fill both windows, then drop the limits below the partial sums
    reconfigure(WINDOW_RESET, WINDOW_RESET);
    repeat (5) send_frame(32'd1_000_000);
    reconfigure(32'd3_000_000, 32'd4_000_000);
    send_frame(32'd1);
    send_frame(32'd3);

    // random phases, with fixed or random limits and one idle mix per group of four
    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0: begin
          rate_w = 32'd0;
          avg_w  = 32'hFFFF_FFFF;
        end
        1: begin
          rate_w = 32'hFFFF_FFFF;
          avg_w  = 32'd0;
        end
        2: begin
          rate_w = WINDOW_RESET;
          avg_w  = WINDOW_RESET;
        end
        default: begin
          rate_w = pick_window();
          avg_w  = pick_window();
        end
      endcase
      reconfigure(rate_w, avg_w);
      if (ph < 4) begin
        send_idle_pct = 29;
        recv_idle_pct = 69;
      end else if (ph < 8) begin
        send_idle_pct = 69;
        recv_idle_pct = 29;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      repeat (150) send_frame(pick_frame($urandom_range(0, 1) ? rate_w : avg_w));
    end

    drain();
    repeat (60) @(posedge clk);
    if (error_count == 0 && pending == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  // run limit
  initial begin
    #15_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
